// File: sv/fpa_pkg.sv
// Package for the fixed-point ALU: opcodes, stage payload type and saturation helpers.
// No dependencies; used by the ALU modules and the testbench, not by the interfaces.
`timescale 1ns / 1ps

package fpa_pkg;

   localparam int FRACTION_BITS_DEFAULT = 8;
   localparam int DIV_STEPS             = 32;

   localparam logic [3:0] OP_ADD     = 4'd0;
   localparam logic [3:0] OP_SUB     = 4'd1;
   localparam logic [3:0] OP_MUL     = 4'd2;
   localparam logic [3:0] OP_DIV     = 4'd3;
   localparam logic [3:0] OP_MIN     = 4'd4;
   localparam logic [3:0] OP_MAX     = 4'd5;
   localparam logic [3:0] OP_INC     = 4'd6;
   localparam logic [3:0] OP_DEC     = 4'd7;
   localparam logic [3:0] OP_TOINT   = 4'd8;
   localparam logic [3:0] OP_FROMINT = 4'd9;

   localparam logic [31:0] MAX_RAW = 32'h7fff_ffff;
   localparam logic [31:0] MIN_RAW = 32'h8000_0000;

   // Payload carried along the pipe after the decode stage
   typedef struct packed {
      logic [3:0]  op;
      logic [31:0] res;    // result of the operations done in the decode stage
      logic        ov;
      logic        gt;
      logic        lt;
      logic        eq;
      logic [63:0] prod;   // signed a*b
      logic        dz;
      logic        big;    // divide quotient at or above 2^32
      logic        neg;    // divide result sign
      logic [31:0] d;      // divisor magnitude
      logic [31:0] rem;    // partial remainder
      logic [31:0] nlow;   // dividend bits still to shift in
      logic [31:0] q;      // quotient bits so far
   } stage_type;

   // {overflow, value} of a signed 64-bit value clamped to 32 bits
   function automatic logic [32:0] sat_signed(input logic signed [63:0] v);
      logic [32:0] r;
      if (v > 64'sd2147483647) begin
         r = {1'b1, MAX_RAW};
      end else if (v < -64'sd2147483648) begin
         r = {1'b1, MIN_RAW};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

   // Same from a magnitude (at most 2^62) and a sign
   function automatic logic [32:0] sat_mag(input logic [63:0] m, input logic neg);
      logic signed [63:0] v;
      v = neg ? -$signed(m) : $signed(m);
      return sat_signed(v);
   endfunction

endpackage

// File: sv/fpa_req_if.sv
// Request channel interface: opcode and two raw operands, valid/ready handshake.
// Depends on nothing.
`timescale 1ns / 1ps

interface fpa_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  req_type;
   logic [31:0] operand_a;
   logic [31:0] operand_b;

   modport source (output valid, req_type, operand_a, operand_b, input ready);
   modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface

// File: sv/fpa_rsp_if.sv
// Response channel interface: raw result, compare flags and error flags.
// Depends on nothing.
`timescale 1ns / 1ps

interface fpa_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_value;
   logic        a_greater;
   logic        a_less;
   logic        a_equal;
   logic        zero_divisor;
   logic        overflowed;

   modport source (output valid, result_value, a_greater, a_less, a_equal,
                   zero_divisor, overflowed, input ready);
   modport sink   (input valid, result_value, a_greater, a_less, a_equal,
                   zero_divisor, overflowed, output ready);
endinterface

// File: sv/fixed_point_alu.sv
// Signed 32-bit fixed-point ALU, top level: front stages, divide pipe, back stage.
// Depends on fpa_pkg, fpa_req_if, fpa_rsp_if, fpa_front, fpa_div_stage, fpa_back.
//
// Usage
//  - req channel: one beat carries req_type, operand_a and operand_b (raw values
//    with FRACTION_BITS fraction bits). rsp channel: one beat per request with
//    result_value, the compare flags, zero_divisor and overflowed.
//  - Path: an accepted req beat passes the input register, decode stage, 32 divide
//    steps and the rounding/output register before rsp valid. All opcodes take
//    the same path, so responses leave in request order.
//  - Throughput: one beat per cycle unless stalled. Divide pipe: one quotient bit
//    per stage, which sets the depth; the 32x32 multiply sits in the decode stage.
//  - Stall: the whole pipe holds while the output beat waits; req.ready is high
//    whenever the output register is empty or being taken, so a new beat enters
//    in the same cycle that a result leaves.
//  - Reset (synchronous): clears every valid bit; payload registers are left.
//  - No state is kept between operations.
`timescale 1ns / 1ps

module fixed_point_alu #(
   parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   fpa_req_if.sink   req,
   fpa_rsp_if.source rsp
);

   logic               adv;       // whole pipe moves this cycle
   logic               fr_valid;
   fpa_pkg::stage_type fr_st;

   logic               dv [fpa_pkg::DIV_STEPS+1];
   fpa_pkg::stage_type ds [fpa_pkg::DIV_STEPS+1];

   assign adv       = !rsp.valid || rsp.ready;
   assign req.ready = adv;

   fpa_front #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (req.valid),
      .in_op     (req.req_type),
      .in_a      (req.operand_a),
      .in_b      (req.operand_b),
      .out_valid (fr_valid),
      .out_st    (fr_st)
   );

   assign dv[0] = fr_valid;
   assign ds[0] = fr_st;

   // restoring divider, quotient bit 31 first
   for (genvar i = 0; i < fpa_pkg::DIV_STEPS; i++) begin : g_div
      fpa_div_stage u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (dv[i]),
         .in_st     (ds[i]),
         .out_valid (dv[i+1]),
         .out_st    (ds[i+1])
      );
   end

   fpa_back #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .en         (adv),
      .in_valid   (dv[fpa_pkg::DIV_STEPS]),
      .in_st      (ds[fpa_pkg::DIV_STEPS]),
      .out_valid  (rsp.valid),
      .out_result (rsp.result_value),
      .out_gt     (rsp.a_greater),
      .out_lt     (rsp.a_less),
      .out_eq     (rsp.a_equal),
      .out_dz     (rsp.zero_divisor),
      .out_ov     (rsp.overflowed)
   );

   // exactly one compare outcome per beat
   a_cmp_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> $onehot({rsp.a_greater, rsp.a_less, rsp.a_equal}))
      else $error("compare flags not one-hot");

   // zero divisor gives -1.0 and never overflow
   a_dz_result: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.zero_divisor) |->
         (!rsp.overflowed && rsp.result_value == 32'd0 - (32'd1 << FRACTION_BITS)))
      else $error("zero divisor result wrong");

   // overflow only ever reports a clamped value
   a_ov_clamp: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.overflowed) |->
         (rsp.result_value == fpa_pkg::MAX_RAW || rsp.result_value == fpa_pkg::MIN_RAW))
      else $error("overflow without saturated result");

endmodule

// File: sv/fpa_front.sv
// Input register plus decode stage: simple ops, compare, product, divide set-up.
// Depends on fpa_pkg.
`timescale 1ns / 1ps

module fpa_front #(
   parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [3:0]         in_op,
   input  logic [31:0]        in_a,
   input  logic [31:0]        in_b,
   output logic               out_valid,
   output fpa_pkg::stage_type out_st
);

   logic               v1_ff, v2_ff;
   logic [3:0]         op1_ff;
   logic [31:0]        a1_ff, b1_ff;
   fpa_pkg::stage_type st_ff, st_in;

   logic signed [63:0] ax, bx;
   logic [31:0]        mag_a, mag_b;
   logic [63:0]        n64;
   logic [32:0]        sr;
   logic [31:0]        ti;

   always_comb begin
      ax    = {{32{a1_ff[31]}}, a1_ff};
      bx    = {{32{b1_ff[31]}}, b1_ff};
      mag_a = a1_ff[31] ? 32'd0 - a1_ff : a1_ff;
      mag_b = b1_ff[31] ? 32'd0 - b1_ff : b1_ff;
      n64   = {32'd0, mag_a} << FRACTION_BITS;
      ti    = mag_a >> FRACTION_BITS;

      st_in.op = op1_ff;
      st_in.gt = $signed(a1_ff) > $signed(b1_ff);
      st_in.lt = $signed(a1_ff) < $signed(b1_ff);
      st_in.eq = a1_ff == b1_ff;

      case (op1_ff)
         fpa_pkg::OP_ADD:     sr = fpa_pkg::sat_signed(ax + bx);
         fpa_pkg::OP_SUB:     sr = fpa_pkg::sat_signed(ax - bx);
         fpa_pkg::OP_MIN:     sr = {1'b0, st_in.lt ? a1_ff : b1_ff};
         fpa_pkg::OP_MAX:     sr = {1'b0, st_in.gt ? a1_ff : b1_ff};
         fpa_pkg::OP_INC:     sr = fpa_pkg::sat_signed(ax + 64'sd1);
         fpa_pkg::OP_DEC:     sr = fpa_pkg::sat_signed(ax - 64'sd1);
         fpa_pkg::OP_TOINT:   sr = {1'b0, a1_ff[31] ? 32'd0 - ti : ti};
         fpa_pkg::OP_FROMINT: sr = fpa_pkg::sat_mag(n64, a1_ff[31]);
         default:             sr = '0;
      endcase
      st_in.res  = sr[31:0];
      st_in.ov   = sr[32];

      st_in.prod = ax * bx;
      st_in.dz   = (op1_ff == fpa_pkg::OP_DIV) && (b1_ff == 32'd0);
      st_in.d    = mag_b;
      st_in.big  = n64[63:32] >= mag_b;
      st_in.neg  = a1_ff[31] ^ b1_ff[31];
      st_in.rem  = n64[63:32];
      st_in.nlow = n64[31:0];
      st_in.q    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op1_ff <= in_op;
         a1_ff  <= in_a;
         b1_ff  <= in_b;
         st_ff  <= st_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_st    = st_ff;

endmodule

// File: sv/fpa_div_stage.sv
// One restoring-division step: one quotient bit per stage, registered.
// Depends on fpa_pkg.
`timescale 1ns / 1ps

module fpa_div_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  fpa_pkg::stage_type in_st,
   output logic               out_valid,
   output fpa_pkg::stage_type out_st
);

   logic               valid_ff;
   fpa_pkg::stage_type st_ff, st_in;
   logic [32:0]        rem2, diff;
   logic               ge;

   always_comb begin
      rem2       = {in_st.rem, in_st.nlow[31]};
      diff       = rem2 - {1'b0, in_st.d};
      ge         = rem2 >= {1'b0, in_st.d};
      st_in      = in_st;
      st_in.rem  = ge ? diff[31:0] : rem2[31:0];
      st_in.nlow = {in_st.nlow[30:0], 1'b0};
      st_in.q    = {in_st.q[30:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_st    = st_ff;

endmodule

// File: sv/fpa_back.sv
// Rounding, sign and saturation for multiply and divide; output register.
// Depends on fpa_pkg.
`timescale 1ns / 1ps

module fpa_back #(
   parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  fpa_pkg::stage_type in_st,
   output logic               out_valid,
   output logic [31:0]        out_result,
   output logic               out_gt,
   output logic               out_lt,
   output logic               out_eq,
   output logic               out_dz,
   output logic               out_ov
);

   logic        valid_ff;
   logic [31:0] res_ff, res_in;
   logic        gt_ff, lt_ff, eq_ff, dz_ff, ov_ff, ov_in;
   logic [63:0] mag_p, qm, qd;
   logic [32:0] sm, sd;
   logic        rnd;

   always_comb begin
      mag_p = in_st.prod[63] ? 64'd0 - in_st.prod : in_st.prod;
      qm    = (mag_p + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
      sm    = fpa_pkg::sat_mag(qm, in_st.prod[63]);

      // half away from zero: bump when twice the remainder reaches the divisor
      rnd   = {in_st.rem, 1'b0} >= {1'b0, in_st.d};
      qd    = {32'd0, in_st.q} + {63'd0, rnd};
      sd    = fpa_pkg::sat_mag(qd, in_st.neg);

      case (in_st.op)
         fpa_pkg::OP_MUL: begin
            res_in = sm[31:0];
            ov_in  = sm[32];
         end
         fpa_pkg::OP_DIV: begin
            if (in_st.dz) begin
               res_in = 32'd0 - (32'd1 << FRACTION_BITS);
               ov_in  = 1'b0;
            end else if (in_st.big) begin
               res_in = in_st.neg ? fpa_pkg::MIN_RAW : fpa_pkg::MAX_RAW;
               ov_in  = 1'b1;
            end else begin
               res_in = sd[31:0];
               ov_in  = sd[32];
            end
         end
         default: begin
            res_in = in_st.res;
            ov_in  = in_st.ov;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
         ov_ff  <= ov_in;
         gt_ff  <= in_st.gt;
         lt_ff  <= in_st.lt;
         eq_ff  <= in_st.eq;
         dz_ff  <= in_st.dz;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = res_ff;
   assign out_gt     = gt_ff;
   assign out_lt     = lt_ff;
   assign out_eq     = eq_ff;
   assign out_dz     = dz_ff;
   assign out_ov     = ov_ff;

endmodule

// File: tb/tb_fixed_point_alu.sv
// Testbench for fixed_point_alu: directed table then random operations, scored
// against an in-bench predictor. Depends on fpa_pkg, fpa_req_if, fpa_rsp_if, RTL.
`timescale 1ns / 1ps

module tb_fixed_point_alu;

   localparam int FB         = 8;
   localparam int LATENCY    = 35;
   localparam int N_RANDOM   = 770;
   localparam int CYCLE_CAP  = 200000;

   typedef struct packed {
      logic [31:0] value;
      logic        gt;
      logic        lt;
      logic        eq;
      logic        dz;
      logic        ov;
   } alu_result_type;

   typedef struct {
      logic [3:0]     op;
      logic [31:0]    a;
      logic [31:0]    b;
      logic           typed;   // expected value below is typed in by hand
      alu_result_type res;
   } stim_row_type;

   logic clock;
   logic reset;
   fpa_req_if req ();
   fpa_rsp_if rsp ();

   fixed_point_alu #(.FRACTION_BITS(FB)) dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source)
   );

   alu_result_type expected_q[$];
   int             errors;
   int             cycles;
   bit             tx_idle_on;      // random gaps on the request side
   bit             rx_idle_on;      // random stalls on the response side
   bit             hold_off_req;    // long receiver hold-off request
   bit             hold_off_busy;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Saturate a wide signed value to 32 bits, flagging overflow
   function automatic logic [32:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return {1'b1, 32'h7fff_ffff};
      if (v < -64'sd2147483648) return {1'b1, 32'h8000_0000};
      return {1'b0, v[31:0]};
   endfunction

   // Work out the ALU result for one request beat
   function automatic alu_result_type alu_predict(input logic [3:0] op,
                                                  input logic [31:0] ra,
                                                  input logic [31:0] rb);
      alu_result_type r;
      longint a, b, p, q, n, d;
      logic [32:0] s;
      a = longint'($signed(ra));
      b = longint'($signed(rb));
      s = 33'd0;
      r = '0;
      r.gt = a > b;
      r.lt = a < b;
      r.eq = a == b;
      case (op)
         fpa_pkg::OP_ADD: s = clamp32(a + b);
         fpa_pkg::OP_SUB: s = clamp32(a - b);
         fpa_pkg::OP_MUL: begin
            p = a * b;
            q = ((p < 0 ? -p : p) + (64'sd1 << (FB - 1))) >>> FB;
            s = clamp32(p < 0 ? -q : q);
         end
         fpa_pkg::OP_DIV: begin
            if (b == 0) begin
               r.dz = 1'b1;
               s = {1'b0, 32'(-(64'sd1 <<< FB))};
            end else begin
               n = (a < 0 ? -a : a) <<< FB;
               d = b < 0 ? -b : b;
               q = (2 * n + d) / (2 * d);
               s = clamp32(((a < 0) != (b < 0)) ? -q : q);
            end
         end
         fpa_pkg::OP_MIN: s = {1'b0, a < b ? ra : rb};
         fpa_pkg::OP_MAX: s = {1'b0, a > b ? ra : rb};
         fpa_pkg::OP_INC: s = clamp32(a + 1);
         fpa_pkg::OP_DEC: s = clamp32(a - 1);
         fpa_pkg::OP_TOINT: begin
            q = (a < 0 ? -a : a) >>> FB;
            s = {1'b0, 32'(a < 0 ? -q : q)};
         end
         fpa_pkg::OP_FROMINT: begin
            q = (a < 0 ? -a : a) <<< FB;
            s = clamp32(a < 0 ? -q : q);
         end
         default: s = 33'd0;
      endcase
      r.value = s[31:0];
      r.ov    = s[32];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      errors++;
      $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
   endtask

   // Request driver: one beat offered, held until accepted
   task automatic send_beat(input logic [3:0] op, input logic [31:0] a,
                            input logic [31:0] b);
      while (tx_idle_on && $urandom_range(99) < 31) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.req_type  <= op;
      req.operand_a <= a;
      req.operand_b <= b;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   // Random operand biased towards edges and small values
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(9))
         0: return 32'h7fff_ffff - $urandom_range(2);
         1: return 32'h8000_0000 + $urandom_range(2);
         2: return 32'($signed($urandom_range(2048)) - 1024);
         3: return 32'd0;
         4: return 32'($urandom_range(65535)) << 8;
         default: return $urandom;
      endcase
   endfunction

   // Scoreboard push on every accepted request beat
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready)
         expected_q.push_back(alu_predict(req.req_type, req.operand_a, req.operand_b));
   end

   // Response checker
   always @(posedge clock) begin
      alu_result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected beat", rsp.result_value, 32'h0);
         end else begin
            want = expected_q.pop_front();
            if (rsp.result_value !== want.value)
               report_mismatch("result_value", rsp.result_value, want.value);
            if (rsp.a_greater !== want.gt)
               report_mismatch("a_greater", 32'(rsp.a_greater), 32'(want.gt));
            if (rsp.a_less !== want.lt)
               report_mismatch("a_less", 32'(rsp.a_less), 32'(want.lt));
            if (rsp.a_equal !== want.eq)
               report_mismatch("a_equal", 32'(rsp.a_equal), 32'(want.eq));
            if (rsp.zero_divisor !== want.dz)
               report_mismatch("zero_divisor", 32'(rsp.zero_divisor), 32'(want.dz));
            if (rsp.overflowed !== want.ov)
               report_mismatch("overflowed", 32'(rsp.overflowed), 32'(want.ov));
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off counted here
   initial begin
      int hold;
      rsp.ready     = 1'b0;
      hold_off_busy = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req && !hold_off_busy) begin
            hold_off_busy = 1'b1;
            hold = 0;
            rsp.ready <= 1'b0;
            while (hold < 120) begin
               @(posedge clock);
               hold++;
            end
            hold_off_busy = 1'b0;
         end
         rsp.ready <= !(rx_idle_on && $urandom_range(99) < 31);
      end
   end

   // Watchdog
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_CAP) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   stim_row_type table_rows[$];

   function automatic stim_row_type row(input logic [3:0] op, input logic [31:0] a,
                                        input logic [31:0] b, input int typed,
                                        input logic [31:0] v, input int dz,
                                        input int ov);
      stim_row_type s;
      s.op = op; s.a = a; s.b = b; s.typed = (typed != 0);
      s.res = '0;
      s.res.value = v; s.res.dz = (dz != 0); s.res.ov = (ov != 0);
      return s;
   endfunction

   initial begin
      stim_row_type   s;
      alu_result_type p;
      logic [3:0]     op;
      errors        = 0;
      tx_idle_on    = 1'b0;
      rx_idle_on    = 1'b0;
      hold_off_req  = 1'b0;
      reset         = 1'b1;
      req.valid     = 1'b0;
      req.req_type  = '0;
      req.operand_a = '0;
      req.operand_b = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows: extremes, every opcode, zero divisor, saturation, unused codes
      table_rows.push_back(row(fpa_pkg::OP_ADD, 32'h7fff_ffff, 32'd1,
                               1, 32'h7fff_ffff, 0, 1));
      table_rows.push_back(row(fpa_pkg::OP_ADD, 32'h8000_0000, 32'hffff_ffff,
                               1, 32'h8000_0000, 0, 1));
      table_rows.push_back(row(fpa_pkg::OP_SUB, 32'h8000_0000, 32'd1,
                               1, 32'h8000_0000, 0, 1));
      table_rows.push_back(row(fpa_pkg::OP_SUB, 32'h7fff_ffff, 32'h8000_0000,
                               1, 32'h7fff_ffff, 0, 1));
      table_rows.push_back(row(fpa_pkg::OP_MUL, 32'h0000_0180, 32'h0000_0080,
                               0, 0, 0, 0));
      table_rows.push_back(row(fpa_pkg::OP_MUL, 32'hffff_fe80, 32'h0000_0080,
                               0, 0, 0, 0));
      table_rows.push_back(row(fpa_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000,
                               1, 32'h7fff_ffff, 0, 1));
      table_rows.push_back(row(fpa_pkg::OP_MUL, 32'h7fff_ffff, 32'h8000_0000,
                               1, 32'h8000_0000, 0, 1));
      table_rows.push_back(row(fpa_pkg::OP_DIV, 32'h0000_0500, 32'd0,
                               1, 32'hffff_ff00, 1, 0));
      table_rows.push_back(row(fpa_pkg::OP_DIV, 32'd0, 32'd0,
                               1, 32'hffff_ff00, 1, 0));
      table_rows.push_back(row(fpa_pkg::OP_DIV, 32'h8000_0000, 32'd1,
                               1, 32'h8000_0000, 0, 1));
      table_rows.push_back(row(fpa_pkg::OP_DIV, 32'h0000_0100, 32'h0000_0300,
                               0, 0, 0, 0));
      table_rows.push_back(row(fpa_pkg::OP_DIV, 32'hffff_ff00, 32'h0000_0200,
                               0, 0, 0, 0));
      table_rows.push_back(row(fpa_pkg::OP_MIN, 32'h8000_0000, 32'h7fff_ffff,
                               1, 32'h8000_0000, 0, 0));
      table_rows.push_back(row(fpa_pkg::OP_MAX, 32'h8000_0000, 32'h7fff_ffff,
                               1, 32'h7fff_ffff, 0, 0));
      table_rows.push_back(row(fpa_pkg::OP_INC, 32'h7fff_ffff, 32'd0,
                               1, 32'h7fff_ffff, 0, 1));
      table_rows.push_back(row(fpa_pkg::OP_DEC, 32'h8000_0000, 32'd0,
                               1, 32'h8000_0000, 0, 1));
      table_rows.push_back(row(fpa_pkg::OP_TOINT, 32'hffff_fe80, 32'd0,
                               1, 32'hffff_ffff, 0, 0));
      table_rows.push_back(row(fpa_pkg::OP_TOINT, 32'h8000_0000, 32'd5,
                               0, 0, 0, 0));
      table_rows.push_back(row(fpa_pkg::OP_FROMINT, 32'h0080_0000, 32'd0,
                               1, 32'h7fff_ffff, 0, 1));
      table_rows.push_back(row(fpa_pkg::OP_FROMINT, 32'hff80_0000, 32'd0,
                               1, 32'h8000_0000, 0, 0));
      table_rows.push_back(row(fpa_pkg::OP_FROMINT, 32'hff7f_ffff, 32'd0,
                               1, 32'h8000_0000, 0, 1));
      table_rows.push_back(row(4'd10, 32'd3, 32'd3, 1, 32'd0, 0, 0));
      table_rows.push_back(row(4'd15, 32'hffff_ffff, 32'h0, 1, 32'd0, 0, 0));

      foreach (table_rows[i]) begin
         s = table_rows[i];
         // typed rows: cross-check the predictor's value and error flags by hand
         if (s.typed) begin
            p = alu_predict(s.op, s.a, s.b);
            if (p.value !== s.res.value || p.dz !== s.res.dz || p.ov !== s.res.ov)
               report_mismatch("table row", p.value, s.res.value);
         end
         send_beat(s.op, s.a, s.b);
      end

      // Sender pauses until everything has drained
      req.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);

      // Receiver holds off while the sender keeps offering beats
      hold_off_req <= 1'b1;
      @(posedge clock);
      hold_off_req <= 1'b0;
      for (int i = 0; i < 60; i++)
         send_beat(4'($urandom_range(9)), pick_operand(), pick_operand());

      // Random part: long stretch without idling, then idling on both sides
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == 200) begin
            tx_idle_on = 1'b1;
            rx_idle_on <= 1'b1;
         end
         op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10))
                                        : 4'($urandom_range(9));
         send_beat(op, pick_operand(),
                   ($urandom_range(15) == 0) ? 32'd0 : pick_operand());
      end
      req.valid <= 1'b0;

      while (expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);

      if (errors == 0 && expected_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
